// ----- rtl/core/tilt_angle_from_acceleration_top_assert.svh -----
// ----------------------------------------------------------------------------
// Tilt angle assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef TILT_ANGLE_FROM_ACCELERATION_TOP_ASSERT_SVH
`define TILT_ANGLE_FROM_ACCELERATION_TOP_ASSERT_SVH

// same-cycle implication
`define TILT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tilt: same-cycle check failed");

// next-cycle implication
`define TILT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tilt: next-cycle check failed");

`endif

// ----- rtl/core/tilt_pkg.sv -----
// ----------------------------------------------------------------------------
// Tilt angle package
// Shared types, constants and the arctangent table.
// ----------------------------------------------------------------------------
package tilt_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int ANGLE_BITS   = 11;
  localparam int Z_BITS       = 32;

  // tenths per radian is 90000/157; reciprocal of 157 is ceil(2^26/157)
  localparam logic [16:0] SCALE_NUM   = 17'd90000;
  localparam logic [18:0] RECIP_157   = 19'd427445;
  localparam logic [9:0]  MAX_TENTHS  = 10'd900;

  typedef enum logic [1:0] {
    AXIS_Z    = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_sel_t;

  typedef struct packed {
    logic root_is_num;  // root feeds the numerator, plain sample the denominator
    logic neg;          // numerator and denominator signs differ
    logic force_zero;   // zero numerator or no axis
    logic force_max;    // zero denominator
  } tilt_flags_t;

  // atan(2^-i) in Q30 radians
  function automatic logic signed [Z_BITS-1:0] atan_q30(input int idx);
    logic signed [Z_BITS-1:0] r;
    case (idx)
      0:  r = 32'sd843314857;
      1:  r = 32'sd497837829;
      2:  r = 32'sd263043837;
      3:  r = 32'sd133525159;
      4:  r = 32'sd67021687;
      5:  r = 32'sd33543516;
      6:  r = 32'sd16775851;
      7:  r = 32'sd8388437;
      8:  r = 32'sd4194283;
      9:  r = 32'sd2097149;
      10: r = 32'sd1048576;
      11: r = 32'sd524288;
      12: r = 32'sd262144;
      13: r = 32'sd131072;
      14: r = 32'sd65536;
      15: r = 32'sd32768;
      16: r = 32'sd16384;
      17: r = 32'sd8192;
      18: r = 32'sd4096;
      19: r = 32'sd2048;
      20: r = 32'sd1024;
      21: r = 32'sd512;
      22: r = 32'sd256;
      23: r = 32'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/tilt_fifo.sv -----
// ----------------------------------------------------------------------------
// Tilt small queue
// Register-based first-in first-out queue with a show-ahead read port.
// ----------------------------------------------------------------------------
module tilt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end
endmodule

// ----- rtl/core/tilt_front.sv -----
// ----------------------------------------------------------------------------
// Tilt front end
// Accepts a sample, picks numerator and denominator sources, sums squares.
// ----------------------------------------------------------------------------
module tilt_front #(
  parameter int SAMPLE_BITS = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] accel_x,
  input  logic signed [SAMPLE_BITS-1:0] accel_y,
  input  logic signed [SAMPLE_BITS-1:0] accel_z,
  input  logic [1:0]                    axis_choice,
  output logic                          fr_valid,
  input  logic                          fr_full,
  output logic [2*SAMPLE_BITS-1:0]      fr_sum,
  output logic [SAMPLE_BITS-1:0]        fr_plain,
  output tilt_pkg::tilt_flags_t         fr_flags
);
  import tilt_pkg::*;

  localparam int S   = SAMPLE_BITS;
  localparam int SQW = 2 * S;

  logic [S-1:0]   mag_x, mag_y, mag_z;
  logic [S-1:0]   mag_a, mag_b;
  logic [SQW-1:0] sum_c;
  logic [S-1:0]   plain_c;
  tilt_flags_t    flags_c;
  logic           take;
  logic           hand_off;

  assign mag_x = accel_x[S-1] ? (~accel_x + 1'b1) : accel_x;
  assign mag_y = accel_y[S-1] ? (~accel_y + 1'b1) : accel_y;
  assign mag_z = accel_z[S-1] ? (~accel_z + 1'b1) : accel_z;

  always_comb begin
    mag_a   = mag_x;
    mag_b   = mag_y;
    plain_c = mag_z;
    flags_c = '0;
    unique case (axis_sel_t'(axis_choice))
      AXIS_Z: begin
        flags_c.root_is_num = 1'b1;
        flags_c.neg         = accel_z[S-1];
        flags_c.force_zero  = (mag_x == '0) && (mag_y == '0);
        flags_c.force_max   = (mag_z == '0);
      end
      AXIS_X: begin
        mag_a               = mag_y;
        mag_b               = mag_z;
        plain_c             = mag_x;
        flags_c.neg         = accel_x[S-1];
        flags_c.force_zero  = (mag_x == '0);
        flags_c.force_max   = (mag_y == '0) && (mag_z == '0);
      end
      AXIS_Y: begin
        mag_a               = mag_x;
        mag_b               = mag_z;
        plain_c             = mag_y;
        flags_c.neg         = accel_y[S-1];
        flags_c.force_zero  = (mag_y == '0);
        flags_c.force_max   = (mag_x == '0) && (mag_z == '0);
      end
      AXIS_NONE: begin
        flags_c.force_zero  = 1'b1;
      end
      default: begin
        flags_c.force_zero  = 1'b1;
      end
    endcase
    sum_c = SQW'(mag_a) * SQW'(mag_a) + SQW'(mag_b) * SQW'(mag_b);
  end

  assign hand_off = fr_valid & ~fr_full;
  assign full     = fr_valid & fr_full;
  assign take     = push & ~full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (take) begin
      fr_valid <= 1'b1;
    end else if (hand_off) begin
      fr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr_sum   <= sum_c;
      fr_plain <= plain_c;
      fr_flags <= flags_c;
    end
  end
endmodule

// ----- rtl/core/tilt_back.sv -----
// ----------------------------------------------------------------------------
// Tilt back end
// Pipelined square root, CORDIC vectoring and scaling to tenths of a degree.
// ----------------------------------------------------------------------------
module tilt_back #(
  parameter int SAMPLE_BITS = 13
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_pop,
  input  logic [2*SAMPLE_BITS-1:0]                  in_sum,
  input  logic [SAMPLE_BITS-1:0]                    in_plain,
  input  tilt_pkg::tilt_flags_t                     in_flags,
  input  logic                                      out_ready,
  output logic                                      out_valid,
  output logic signed [tilt_pkg::ANGLE_BITS-1:0]    out_angle
);
  import tilt_pkg::*;

  localparam int S   = SAMPLE_BITS;
  localparam int SQW = 2 * S;
  localparam int NR  = S + FRAC_BITS;   // root bits, one per stage
  localparam int RTW = S + FRAC_BITS;
  localparam int RMW = RTW + 3;
  localparam int CW  = S + FRAC_BITS + 2;
  localparam int CS  = CORDIC_STEPS;

  logic adv;

  // square root stages
  logic           sv    [NR];
  logic [RMW-1:0] srem  [NR];
  logic [RTW-1:0] sroot [NR];
  logic [SQW-1:0] srad  [NR];
  logic [S-1:0]   splain[NR];
  tilt_flags_t    sflg  [NR];
  logic [RMW-1:0] nrem  [NR];
  logic [RTW-1:0] nroot [NR];
  logic [SQW-1:0] nrad  [NR];

  // CORDIC stages
  logic                     cv  [CS];
  logic signed [CW-1:0]     cx  [CS];
  logic signed [CW-1:0]     cy  [CS];
  logic signed [Z_BITS-1:0] cz  [CS];
  tilt_flags_t              cfl [CS];
  logic signed [CW-1:0]     nx  [CS];
  logic signed [CW-1:0]     ny  [CS];
  logic signed [Z_BITS-1:0] nz  [CS];

  // scaling stages
  logic        v1, v2;
  logic [47:0] q1;
  logic [36:0] t2;
  tilt_flags_t f1, f2;
  logic [30:0] z_pos;
  logic [10:0] mag;
  logic [9:0]  mag_sat;

  assign adv    = out_ready;
  assign in_pop = adv & in_valid;

  always_comb begin
    logic [RMW-1:0] s_rem;
    logic [RTW-1:0] s_root;
    logic [SQW-1:0] s_rad;
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;
    for (int k = 0; k < NR; k++) begin
      if (k == 0) begin
        s_rem  = '0;
        s_root = '0;
        s_rad  = in_sum;
      end else begin
        s_rem  = srem[k-1];
        s_root = sroot[k-1];
        s_rad  = srad[k-1];
      end
      rem_sh = {s_rem[RMW-3:0], s_rad[SQW-1 -: 2]};
      trial  = {1'b0, s_root, 2'b01};
      if (rem_sh >= trial) begin
        nrem[k]  = rem_sh - trial;
        nroot[k] = {s_root[RTW-2:0], 1'b1};
      end else begin
        nrem[k]  = rem_sh;
        nroot[k] = {s_root[RTW-2:0], 1'b0};
      end
      nrad[k] = {s_rad[SQW-3:0], 2'b00};
    end
  end

  always_comb begin
    logic [RTW-1:0]           num_v, den_v;
    logic signed [CW-1:0]     s_x, s_y;
    logic signed [Z_BITS-1:0] s_z;
    num_v = sflg[NR-1].root_is_num ? sroot[NR-1] : {splain[NR-1], FRAC_BITS'(0)};
    den_v = sflg[NR-1].root_is_num ? {splain[NR-1], FRAC_BITS'(0)} : sroot[NR-1];
    for (int i = 0; i < CS; i++) begin
      if (i == 0) begin
        s_x = signed'(CW'(den_v));
        s_y = signed'(CW'(num_v));
        s_z = '0;
      end else begin
        s_x = cx[i-1];
        s_y = cy[i-1];
        s_z = cz[i-1];
      end
      if (!s_y[CW-1]) begin
        nx[i] = s_x + (s_y >>> i);
        ny[i] = s_y - (s_x >>> i);
        nz[i] = s_z + atan_q30(i);
      end else begin
        nx[i] = s_x - (s_y >>> i);
        ny[i] = s_y + (s_x >>> i);
        nz[i] = s_z - atan_q30(i);
      end
    end
  end

  assign z_pos = cz[CS-1][Z_BITS-1] ? '0 : cz[CS-1][30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NR; k++) sv[k] <= 1'b0;
      for (int i = 0; i < CS; i++) cv[i] <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k < NR; k++) sv[k] <= (k == 0) ? in_valid : sv[k-1];
      for (int i = 0; i < CS; i++) cv[i] <= (i == 0) ? sv[NR-1] : cv[i-1];
      v1 <= cv[CS-1];
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NR; k++) begin
        srem[k]   <= nrem[k];
        sroot[k]  <= nroot[k];
        srad[k]   <= nrad[k];
        splain[k] <= (k == 0) ? in_plain : splain[k-1];
        sflg[k]   <= (k == 0) ? in_flags : sflg[k-1];
      end
      for (int i = 0; i < CS; i++) begin
        cx[i]  <= nx[i];
        cy[i]  <= ny[i];
        cz[i]  <= nz[i];
        cfl[i] <= (i == 0) ? sflg[NR-1] : cfl[i-1];
      end
      q1 <= 48'(z_pos) * 48'(SCALE_NUM);
      f1 <= cfl[CS-1];
      t2 <= 37'(q1[47:30]) * 37'(RECIP_157);
      f2 <= f1;
    end
  end

  // t2 >> 26 is floor(q / (157 * 2^30)), exact for this range
  assign mag     = t2[36:26];
  assign mag_sat = (mag > 11'(MAX_TENTHS)) ? MAX_TENTHS : mag[9:0];

  always_comb begin
    logic [ANGLE_BITS-1:0] m;
    if (f2.force_zero) begin
      m = '0;
    end else if (f2.force_max) begin
      m = ANGLE_BITS'(MAX_TENTHS);
    end else begin
      m = ANGLE_BITS'(mag_sat);
    end
    out_angle = f2.neg ? signed'(-m) : signed'(m);
  end

  assign out_valid = v2;
endmodule

// ----- rtl/core/tilt_angle_from_acceleration_top.sv -----
// ----------------------------------------------------------------------------
// Tilt angle from acceleration
// Queue-style wrapper: front end, middle queue, arithmetic back end, output
// queue.
// ----------------------------------------------------------------------------
// Takes one signed three-axis sample per word with an axis selector and
// returns one signed angle in tenths of a degree per word (selector 0: angle
// to Z, 1: to X, 2: to Y, 3: zero; a zero denominator gives +/-900 and 0/0
// gives 0). Words flow at one per clock cycle with no gaps when the result
// side keeps popping. The path from push to the output runs through one front
// register, one middle queue slot, SAMPLE_BITS + 16 square root stages (one
// root bit each), 24 CORDIC stages, two scaling multiplier stages and the
// output queue. When the output queue fills the whole back end holds, the
// middle queue absorbs the front, and full rises only once both are backed
// up. There is no state kept between words, so there is no clearing pass
// after reset.
// ----------------------------------------------------------------------------
module tilt_angle_from_acceleration_top #(
  parameter int SAMPLE_BITS = 13
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [SAMPLE_BITS-1:0]          accel_x,
  input  logic signed [SAMPLE_BITS-1:0]          accel_y,
  input  logic signed [SAMPLE_BITS-1:0]          accel_z,
  input  logic [1:0]                             axis_choice,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [tilt_pkg::ANGLE_BITS-1:0] angle_tenths
);
  import tilt_pkg::*;

  `include "tilt_angle_from_acceleration_top_assert.svh"

  localparam int S  = SAMPLE_BITS;
  localparam int MW = 2 * S + S + $bits(tilt_flags_t);

  // front -> middle queue
  logic           fr_valid;
  logic           mid_full;
  logic [2*S-1:0] fr_sum;
  logic [S-1:0]   fr_plain;
  tilt_flags_t    fr_flags;

  // middle queue -> back
  logic           mid_empty;
  logic           mid_pop;
  logic [MW-1:0]  mid_rdata;
  logic [2*S-1:0] mid_sum;
  logic [S-1:0]   mid_plain;
  tilt_flags_t    mid_flags;

  // back -> output queue
  logic                         out_full;
  logic                         back_valid;
  logic signed [ANGLE_BITS-1:0] back_angle;
  logic [ANGLE_BITS-1:0]        out_rdata;

  tilt_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .accel_x     (accel_x),
    .accel_y     (accel_y),
    .accel_z     (accel_z),
    .axis_choice (axis_choice),
    .fr_valid    (fr_valid),
    .fr_full     (mid_full),
    .fr_sum      (fr_sum),
    .fr_plain    (fr_plain),
    .fr_flags    (fr_flags)
  );

  // decouples classification from the arithmetic pipe
  tilt_fifo #(.WIDTH(MW), .DEPTH(2)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (fr_valid),
    .wdata ({fr_sum, fr_plain, fr_flags}),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign {mid_sum, mid_plain, mid_flags} = mid_rdata;

  tilt_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (~mid_empty),
    .in_pop    (mid_pop),
    .in_sum    (mid_sum),
    .in_plain  (mid_plain),
    .in_flags  (mid_flags),
    .out_ready (~out_full),
    .out_valid (back_valid),
    .out_angle (back_angle)
  );

  // result skid: lets the pipe run while a finished word waits
  tilt_fifo #(.WIDTH(ANGLE_BITS), .DEPTH(2)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (back_valid),
    .wdata (back_angle),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign angle_tenths = signed'(out_rdata);

  // a stalled back end must hold its finished word unchanged
  `TILT_ASSERT_NEXT(a_back_hold, back_valid && out_full, back_valid && $stable(back_angle))
  // angles never leave the +/-900 range
  `TILT_ASSERT_NOW(a_angle_range, back_valid,
                   back_angle <= 11'sd900 && back_angle >= -11'sd900)
  // a word handed to the middle queue is visible to the back end next cycle
  `TILT_ASSERT_NEXT(a_mid_fill, fr_valid && !mid_full, !mid_empty)
endmodule
